>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and the rotate helper of the SHA-256 block.
// ----------------------------------------------------------------------------
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       put_byte;   // write put_value at the current byte position
      logic [7:0] put_value;
      logic       count_byte; // add eight to the bit count
      logic       load_vars;  // working variables from the hash
      logic       round;      // one compression round
      logic       add_hash;   // fold working variables into the hash
      logic       restore;    // initial hash, clear count and position
   } cmd_type;

   typedef struct packed {
      logic [5:0] byte_pos;
      logic [5:0] round_idx;
      logic [63:0] bit_count;
   } status_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

>>> rtl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// Byte-serial SHA-256 engine: message bytes in, eight digest words out.
// ----------------------------------------------------------------------------
// One byte per transaction, accepted while idle; the sixty-fourth byte of a
// block starts a compression (one round per cycle in the round datapath)
// and the hash update, with req_stall high throughout. An end transaction
// pads byte by byte (up to one extra block), compresses, then offers the
// eight digest words, word 0 first, with last_word on word 7; the initial
// hash is restored after the last word.
// A transaction with neither a byte nor the end flag does nothing.
module sha256_message_digest
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   cmd_type     cmd;
   status_type  status;
   logic [31:0] hash_word [8];
   logic [2:0]  out_idx;

   sha_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_msg_byte,
      .req_byte_present, .req_end_of_message, .status, .cmd,
      .rsp_valid, .rsp_stall, .out_idx);

   sha_datapath u_datapath (
      .clock, .reset, .cmd, .status, .hash_word);

   // the hash holds still while words are offered
   assign rsp_digest_word = hash_word[out_idx];
   assign rsp_word_index  = out_idx;
   assign rsp_last_word   = (out_idx == 3'd7);

endmodule

>>> rtl/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, message schedule, working variables, hash and length count.
// ----------------------------------------------------------------------------
module sha_datapath
   import sha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   status,
   output logic [31:0]  hash_word [8]
);

   logic [31:0] hash_ff [8];
   logic [31:0] var_ff [8];
   logic [31:0] blk_ff [16];
   logic [5:0]  pos_ff;
   logic [5:0]  rnd_ff;
   logic [63:0] cnt_ff;

   logic [3:0]  slot;
   logic [31:0] w2, w7, w15, w_new, w_use, t1, t2, s0, s1, ch, maj;

   always_comb begin
      slot  = rnd_ff[3:0];
      w2    = blk_ff[slot + 4'd14];
      w7    = blk_ff[slot + 4'd9];
      w15   = blk_ff[slot + 4'd1];
      w_new = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w7
            + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + blk_ff[slot];
      w_use = (rnd_ff[5:4] != 2'd0) ? w_new : blk_ff[slot];
      s1  = rotr(var_ff[4], 6) ^ rotr(var_ff[4], 11) ^ rotr(var_ff[4], 25);
      ch  = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      t1  = var_ff[7] + s1 + ch + ROUND_K[rnd_ff] + w_use;
      s0  = rotr(var_ff[0], 2) ^ rotr(var_ff[0], 13) ^ rotr(var_ff[0], 22);
      maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t2  = s0 + maj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rnd_ff <= '0;
         cnt_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= INIT_HASH[i];
            var_ff[i]  <= '0;
         end
      end else begin
         if (cmd.put_byte) begin
            if (pos_ff[1:0] == 2'd0)
               blk_ff[pos_ff[5:2]] <= {cmd.put_value, 24'd0};
            else
               blk_ff[pos_ff[5:2]] <= blk_ff[pos_ff[5:2]]
                  | ({24'd0, cmd.put_value} << {(2'd3 - pos_ff[1:0]), 3'd0});
            pos_ff <= pos_ff + 6'd1;
         end
         if (cmd.count_byte)
            cnt_ff <= cnt_ff + 64'd8;
         if (cmd.load_vars)
            for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
         if (cmd.round) begin
            blk_ff[slot] <= w_use;
            var_ff[7] <= var_ff[6];
            var_ff[6] <= var_ff[5];
            var_ff[5] <= var_ff[4];
            var_ff[4] <= var_ff[3] + t1;
            var_ff[3] <= var_ff[2];
            var_ff[2] <= var_ff[1];
            var_ff[1] <= var_ff[0];
            var_ff[0] <= t1 + t2;
            rnd_ff    <= rnd_ff + 6'd1;
         end
         if (cmd.add_hash)
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + var_ff[i];
         if (cmd.restore) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
            cnt_ff <= '0;
            pos_ff <= '0;
         end
      end
   end

   assign status.byte_pos  = pos_ff;
   assign status.round_idx = rnd_ff;
   assign status.bit_count = cnt_ff;
   always_comb
      for (int i = 0; i < 8; i++) hash_word[i] = hash_ff[i];

endmodule

>>> rtl/sha_control.sv
// ----------------------------------------------------------------------------
// sha_control
// Sequencer: byte intake, padding, length, rounds and digest output.
// ----------------------------------------------------------------------------
module sha_control
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   input  status_type  status,
   output cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  out_idx
);

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;    // where to go after a compression
   logic        fin_ff, fin_in;    // end of message pending
   logic [63:0] len_ff, len_in;    // length latched at each accepted item; the end item's value is used
   logic [2:0]  idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         fin_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fin_ff   <= fin_in;
         idx_ff   <= idx_in;
      end
      len_ff <= len_in;
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fin_in    = fin_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.put_byte   = req_byte_present;
               cmd.put_value  = req_msg_byte;
               cmd.count_byte = req_byte_present;
               len_in = status.bit_count + (req_byte_present ? 64'd8 : 64'd0);
               if (req_end_of_message) begin
                  fin_in = 1'b1;
                  ret_in = ST_PAD;
               end else begin
                  ret_in = ST_IDLE;
               end
               if (req_byte_present && status.byte_pos == 6'd63) begin
                  cmd.load_vars = 1'b1;
                  state_in = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // 0x80 marker, then zeros up to the length field, compressing a full block on the way if needed
            cmd.put_byte  = 1'b1;
            cmd.put_value = fin_ff ? PAD_BYTE : 8'd0;
            fin_in = 1'b0;
            if (status.byte_pos == 6'd63) begin
               cmd.load_vars = 1'b1;
               ret_in   = ST_PAD;
               state_in = ST_ROUND;
            end else if (status.byte_pos + 6'd1 == LEN_POS) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.put_byte  = 1'b1;
            cmd.put_value = len_ff[8 * (7 - status.byte_pos[2:0]) +: 8];
            if (status.byte_pos == 6'd63) begin
               cmd.load_vars = 1'b1;
               ret_in   = ST_OUT;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.round_idx == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_hash = 1'b1;
            state_in = ret_ff;
            idx_in   = '0;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.restore = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_idx = idx_ff;

endmodule
